[hw/rtl/spc_pkg.sv]
// spc_pkg: shared constants and helpers for the spherical-to-Cartesian point unit.
// Holds op codes, fixed-point constants and the CORDIC arc table.
// No dependencies.
package spc_pkg;

  localparam int IN_DATA_W      = 32;
  localparam int IN_USER_W      = 2;
  localparam int FIELD_W        = 16;
  localparam int MAX_FIELD_BITS = 24;
  localparam int FRAC           = 14;
  localparam int LO_BITS        = 20;
  localparam int TABLE_LEN      = 24;
  localparam int Q_DEPTH        = 4;
  localparam int Q_AW           = 2;

  localparam logic [23:0] K_Q24            = 24'd10188014;
  localparam logic [31:0] ELEV_RESET_MAG32 = 32'd715761200;

  localparam logic [1:0] OP_SET_AZ = 2'd0;
  localparam logic [1:0] OP_SET_EL = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;

  function automatic logic [31:0] arc(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

[hw/rtl/spc_front.sv]
// spc_front: input side; latches angles and queues range samples with a snapshot
// of both angles and the point index. Depends on spc_pkg.
module spc_front #(
  parameter int ANGLE_BITS = 16,
  parameter int RANGE_BITS = 16,
  parameter int ENTRY_W    = 32 + 2 * ANGLE_BITS + RANGE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [spc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [spc_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [ENTRY_W-1:0]            q_wdata
);

  localparam logic [63:0] EL_MAG = (64'(spc_pkg::ELEV_RESET_MAG32)
                                    + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] EL_RESET = ANGLE_BITS'(64'd0 - EL_MAG);

  logic [ANGLE_BITS-1:0] az_r, az_nxt, el_r, el_nxt;
  logic [31:0]           cnt_r, cnt_nxt;
  logic [spc_pkg::MAX_FIELD_BITS-1:0] ang_ext, dist_ext;
  logic                  acc;

  assign ang_ext  = spc_pkg::MAX_FIELD_BITS'(in_tdata[spc_pkg::FIELD_W-1:0]);
  assign dist_ext = spc_pkg::MAX_FIELD_BITS'(in_tdata[2*spc_pkg::FIELD_W-1:spc_pkg::FIELD_W]);
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign q_push    = acc && (in_tuser == spc_pkg::OP_RANGE);
  assign q_wdata   = {cnt_r, el_r, az_r, dist_ext[RANGE_BITS-1:0]};

  always_comb begin
    az_nxt  = az_r;
    el_nxt  = el_r;
    cnt_nxt = cnt_r;
    if (acc && in_tuser == spc_pkg::OP_SET_AZ) az_nxt = ang_ext[ANGLE_BITS-1:0];
    if (acc && in_tuser == spc_pkg::OP_SET_EL) el_nxt = ang_ext[ANGLE_BITS-1:0];
    if (q_push) cnt_nxt = cnt_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_r  <= '0;
      el_r  <= EL_RESET;
      cnt_r <= '0;
    end else begin
      az_r  <= az_nxt;
      el_r  <= el_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/spc_queue.sv]
// spc_queue: short show-ahead FIFO between front and back.
// Depends on spc_pkg for depth constants.
module spc_queue #(
  parameter int WIDTH = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             not_empty
);

  logic [WIDTH-1:0]        mem [spc_pkg::Q_DEPTH];
  logic [spc_pkg::Q_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [spc_pkg::Q_AW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (spc_pkg::Q_AW+1)'(spc_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (spc_pkg::Q_AW+1)'(push) - (spc_pkg::Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/spc_back.sv]
// spc_back: sequencer that runs two iterative CORDIC rotations per point,
// with gain compensation and rounding, into an output register. Depends on spc_pkg.
module spc_back #(
  parameter int ANGLE_BITS    = 16,
  parameter int RANGE_BITS    = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int ENTRY_W       = 32 + 2 * ANGLE_BITS + RANGE_BITS,
  parameter int OUT_DATA_W    = ((3 * (RANGE_BITS + 1) + 32 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [ENTRY_W-1:0]    q_data,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int W  = RANGE_BITS + 17;
  localparam int PW = RANGE_BITS + 24;
  localparam int OW = RANGE_BITS + 1;
  localparam logic [4:0] LAST = 5'(CORDIC_STAGES - 1);
  localparam logic signed [W-1:0] CMAX = W'((64'd1 << RANGE_BITS) - 64'd1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOAD1 = 8'b00000010,
    S_ROT1  = 8'b00000100,
    S_MLO   = 8'b00001000,
    S_MHI   = 8'b00010000,
    S_LOAD2 = 8'b00100000,
    S_ROT2  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic signed [W-1:0]    x_r, x_nxt, y_r, y_nxt, zc_r, zc_nxt;
  logic [31:0]            z_r, z_nxt;
  logic [4:0]             step_r, step_nxt;
  logic [43:0]            plo_r, plo_nxt;
  logic signed [W+4:0]    phi_r, phi_nxt;
  logic [ANGLE_BITS-1:0]  az_r, az_nxt;
  logic [31:0]            idx_r, idx_nxt;
  logic                   ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0]  od_r, od_nxt;

  logic signed [W-1:0]    rx, ry, lx;
  logic [31:0]            rz, lz;
  logic signed [W+4:0]    hi_ext, k_ext;
  logic signed [W+24:0]   sum;

  function automatic logic [OW-1:0] fin(input logic signed [W-1:0] v);
    logic signed [W-1:0] s;
    s = (v + $signed(W'(64'd1 << (spc_pkg::FRAC - 1)))) >>> spc_pkg::FRAC;
    if (s > CMAX) s = CMAX;
    if (s < -CMAX) s = -CMAX;
    return s[OW-1:0];
  endfunction

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    rx = z_r[31] ? x_r + (y_r >>> step_r) : x_r - (y_r >>> step_r);
    ry = z_r[31] ? y_r - (x_r >>> step_r) : y_r + (x_r >>> step_r);
    rz = z_r[31] ? z_r + spc_pkg::arc(step_r) : z_r - spc_pkg::arc(step_r);
    hi_ext = (W+5)'($signed(x_r[W-1:spc_pkg::LO_BITS]));
    k_ext  = (W+5)'($signed({1'b0, spc_pkg::K_Q24}));
    sum = ((W+25)'(phi_r) <<< spc_pkg::LO_BITS) + $signed((W+25)'(plo_r));
  end

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    zc_nxt    = zc_r;
    step_nxt  = step_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    az_nxt    = az_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    lx        = '0;
    lz        = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          prod_nxt = PW'(q_data[RANGE_BITS-1:0]) * PW'(spc_pkg::K_Q24);
          az_nxt   = q_data[RANGE_BITS+ANGLE_BITS-1:RANGE_BITS];
          z_nxt    = {q_data[RANGE_BITS+2*ANGLE_BITS-1:RANGE_BITS+ANGLE_BITS],
                      {(32-ANGLE_BITS){1'b0}}};
          idx_nxt  = q_data[ENTRY_W-1:ENTRY_W-32];
          state_nxt = S_LOAD1;
        end
      end
      S_LOAD1: begin
        lx = W'(prod_r[PW-1:24-spc_pkg::FRAC]);
        if (z_r[31:30] == 2'b01 || z_r[31:30] == 2'b10) begin
          x_nxt = -lx;
          z_nxt = z_r + 32'h80000000;
        end else begin
          x_nxt = lx;
        end
        y_nxt     = '0;
        step_nxt  = '0;
        state_nxt = S_ROT1;
      end
      S_ROT1: begin
        x_nxt    = rx;
        y_nxt    = ry;
        z_nxt    = rz;
        step_nxt = step_r + 5'd1;
        if (step_r == LAST) begin
          zc_nxt    = ry;
          state_nxt = S_MLO;
        end
      end
      S_MLO: begin
        plo_nxt   = 44'(x_r[spc_pkg::LO_BITS-1:0]) * 44'(spc_pkg::K_Q24);
        state_nxt = S_MHI;
      end
      S_MHI: begin
        phi_nxt   = hi_ext * k_ext;
        state_nxt = S_LOAD2;
      end
      S_LOAD2: begin
        lx = sum[W+23:24];
        lz = {az_r, {(32-ANGLE_BITS){1'b0}}};
        if (lz[31:30] == 2'b01 || lz[31:30] == 2'b10) begin
          x_nxt = -lx;
          z_nxt = lz + 32'h80000000;
        end else begin
          x_nxt = lx;
          z_nxt = lz;
        end
        y_nxt     = '0;
        step_nxt  = '0;
        state_nxt = S_ROT2;
      end
      S_ROT2: begin
        x_nxt    = rx;
        y_nxt    = ry;
        z_nxt    = rz;
        step_nxt = step_r + 5'd1;
        if (step_r == LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = OUT_DATA_W'({idx_r, fin(zc_r), fin(y_r), fin(x_r)});
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zc_r   <= zc_nxt;
    step_r <= step_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    az_r   <= az_nxt;
    idx_r  <= idx_nxt;
    od_r   <= od_nxt;
  end

endmodule

[hw/rtl/spherical_to_cartesian_point_unit.sv]
// spherical_to_cartesian_point_unit: top level of the lidar point builder.
// Instantiates spc_front, spc_queue and spc_back; uses spc_pkg.
//
//   port group | dir | fields (low bit up)
//   in_*       | in  | tuser: op[1:0]; tdata: angle[15:0], distance[31:16]
//   out_*      | out | tdata: x_pos, y_pos, z_pos (RANGE_BITS+1 each), point_index[31:0]
//
// Angle-update transfers are latched in the front end and are not queued.
// Each range sample runs twice through the single iterative CORDIC rotator in the
// back end, which takes no new sample until the current point reaches the output register.
// A 4-entry queue lets the front keep taking transfers while the back works.
// Reset: synchronous; no clearing pass. Output register holds under stall.
module spherical_to_cartesian_point_unit #(
  parameter int ANGLE_BITS    = 16,
  parameter int RANGE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [spc_pkg::IN_DATA_W-1:0] in_tdata,  // angle, distance
  input  logic [spc_pkg::IN_USER_W-1:0] in_tuser,  // op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [((3*(RANGE_BITS+1)+32+7)/8)*8-1:0] out_tdata // x, y, z, point_index
);

  localparam int ENTRY_W = 32 + 2 * ANGLE_BITS + RANGE_BITS;

  logic               q_push, q_pop, q_full, q_ne;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  spc_front #(
    .ANGLE_BITS(ANGLE_BITS), .RANGE_BITS(RANGE_BITS), .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .q_full(q_full),
    .q_push(q_push), .q_wdata(q_wdata)
  );

  spc_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .not_empty(q_ne)
  );

  spc_back #(
    .ANGLE_BITS(ANGLE_BITS), .RANGE_BITS(RANGE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES), .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_data(q_rdata), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
